FILE: hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared definitions for the complex arithmetic unit
// Word format, operation and status codes, pipeline sideband, saturation.
// ----------------------------------------------------------------------------
package cau_pkg;

  // Component format: signed fixed point
  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  // Full product width and the widened width used ahead of saturation
  localparam int PW = 2 * WORD_BITS;
  localparam int SW = PW + 2;
  // Quotient bits kept by the divider and low numerator bits fed in per step
  localparam int QB = WORD_BITS + 1;
  localparam int NLOW = QB - FRAC_BITS;

  localparam int TOL_BITS = 31;
  localparam logic [TOL_BITS-1:0] TOL_RESET =
    TOL_BITS'(((64'd1 << FRAC_BITS) + 64'd50) / 64'd100);

  // Register stages from the accepting edge to the result strobe
  localparam int LATENCY = 6 + QB;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_CONJ = 3'd4,
    OP_MOD  = 3'd5,
    OP_EQ   = 3'd6,
    OP_NONE = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DIV0 = 2'd1,
    ST_SAT  = 2'd2
  } status_e;

  // Per-item data that rides alongside the divider
  typedef struct packed {
    op_e                   op;
    logic signed [SW-1:0]  pre_re;
    logic signed [SW-1:0]  pre_im;
    logic                  eq;
    logic                  dz;
    logic                  neg_re;
    logic                  neg_im;
    logic                  ovf_re;
    logic                  ovf_im;
  } side_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] val;
    logic                 sat;
  } sat_t;

  // Clamp a widened value to one component word
  function automatic sat_t saturate(input logic signed [SW-1:0] x);
    sat_t r;
    logic fits;
    fits = (&x[SW-1:WORD_BITS-1]) | ~(|x[SW-1:WORD_BITS-1]);
    r.sat = ~fits;
    if (fits) begin
      r.val = x[WORD_BITS-1:0];
    end else if (x[SW-1]) begin
      r.val = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      r.val = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: hdl/cau_div_pipe.sv
// ----------------------------------------------------------------------------
// cau_div_pipe: pipelined restoring divider, two lanes on one divisor
// One quotient bit per stage, most significant first; sideband travels along.
// ----------------------------------------------------------------------------
module cau_div_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [cau_pkg::PW-1:0]        den_i,
  input  logic [cau_pkg::PW-1:0]        nre_i,
  input  logic [cau_pkg::PW-1:0]        nim_i,
  input  cau_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [cau_pkg::QB-1:0]        qre_o,
  output logic [cau_pkg::QB-1:0]        qim_o,
  output cau_pkg::side_t                side_o
);

  localparam int PW   = cau_pkg::PW;
  localparam int QB   = cau_pkg::QB;
  localparam int NLOW = cau_pkg::NLOW;

  logic [QB-1:0]    v_q;
  logic [PW-1:0]    d_q   [QB];
  logic [PW-1:0]    rre_q [QB];
  logic [PW-1:0]    rim_q [QB];
  logic [QB-1:0]    qre_q [QB];
  logic [QB-1:0]    qim_q [QB];
  logic [NLOW-1:0]  lre_q [QB];
  logic [NLOW-1:0]  lim_q [QB];
  cau_pkg::side_t   sd_q  [QB];

  // One trial subtract: returns {quotient bit, next remainder}
  function automatic logic [PW:0] dstep(input logic [PW-1:0] r, input logic nb,
                                        input logic [PW-1:0] d);
    logic [PW:0]   t;
    logic [PW+1:0] diff;
    logic          ge;
    t    = {r, nb};
    diff = {1'b0, t} - {2'b00, d};
    ge   = ~diff[PW+1];
    return {ge, (ge ? diff[PW-1:0] : t[PW-1:0])};
  endfunction

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int J = QB - 1 - k;
    logic [PW-1:0]   d_in, rre_in, rim_in;
    logic [QB-1:0]   qre_in, qim_in;
    logic [NLOW-1:0] lre_in, lim_in;
    cau_pkg::side_t  sd_in;
    logic            v_in;
    logic            nb_re, nb_im;
    logic [PW:0]     st_re, st_im;
    logic [QB-1:0]   qre_d, qim_d;

    // Select stage input: ports for the first stage, previous stage after
    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign d_in   = den_i;
      assign rre_in = nre_i >> NLOW;
      assign rim_in = nim_i >> NLOW;
      assign qre_in = '0;
      assign qim_in = '0;
      assign lre_in = nre_i[NLOW-1:0];
      assign lim_in = nim_i[NLOW-1:0];
      assign sd_in  = side_i;
    end else begin : g_next
      assign v_in   = v_q[k-1];
      assign d_in   = d_q[k-1];
      assign rre_in = rre_q[k-1];
      assign rim_in = rim_q[k-1];
      assign qre_in = qre_q[k-1];
      assign qim_in = qim_q[k-1];
      assign lre_in = lre_q[k-1];
      assign lim_in = lim_q[k-1];
      assign sd_in  = sd_q[k-1];
    end

    // Bring down the next dividend bit; below the fraction shift it is zero
    if (J >= cau_pkg::FRAC_BITS) begin : g_nb
      assign nb_re = lre_in[J-cau_pkg::FRAC_BITS];
      assign nb_im = lim_in[J-cau_pkg::FRAC_BITS];
    end else begin : g_nz
      assign nb_re = 1'b0;
      assign nb_im = 1'b0;
    end

    assign st_re = dstep(rre_in, nb_re, d_in);
    assign st_im = dstep(rim_in, nb_im, d_in);

    always_comb begin
      qre_d    = qre_in;
      qim_d    = qim_in;
      qre_d[J] = st_re[PW];
      qim_d[J] = st_im[PW];
    end

    // Advance valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
    end

    // Advance payload
    always_ff @(posedge clk_i) begin
      d_q[k]   <= d_in;
      rre_q[k] <= st_re[PW-1:0];
      rim_q[k] <= st_im[PW-1:0];
      qre_q[k] <= qre_d;
      qim_q[k] <= qim_d;
      lre_q[k] <= lre_in;
      lim_q[k] <= lim_in;
      sd_q[k]  <= sd_in;
    end
  end

  assign valid_o = v_q[QB-1];
  assign qre_o   = qre_q[QB-1];
  assign qim_o   = qim_q[QB-1];
  assign side_o  = sd_q[QB-1];

endmodule

FILE: hdl/complex_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top: pipelined fixed-point complex arithmetic unit
//
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+--------------------
//  command  | start_i, busy_o, op_i, a_*_i, b_*_i       | start_i & !busy_o
//  config   | cfg_valid_i, cfg_ready_o, cfg_data_i      | cfg_valid_i & ready
//  result   | done_o, out_real_o, out_imag_o, equal_o,  | done_o (one cycle)
//           | status_o                                  |
//
// A command can be taken every cycle; busy_o stays low.
// Every operation has the same latency, set by the 33 divider stages plus six
// other register stages.
// Reset clears all valid bits and loads the default tolerance.
// The result side has no backpressure, so the pipeline never stalls.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [2:0]                          op_i,
  input  logic signed [cau_pkg::WORD_BITS-1:0] a_real_i,
  input  logic signed [cau_pkg::WORD_BITS-1:0] a_imag_i,
  input  logic signed [cau_pkg::WORD_BITS-1:0] b_real_i,
  input  logic signed [cau_pkg::WORD_BITS-1:0] b_imag_i,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cau_pkg::TOL_BITS-1:0]        cfg_data_i,
  output logic                                done_o,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_real_o,
  output logic signed [cau_pkg::WORD_BITS-1:0] out_imag_o,
  output logic                                equal_o,
  output logic [1:0]                          status_o
);

  localparam int W  = cau_pkg::WORD_BITS;
  localparam int F  = cau_pkg::FRAC_BITS;
  localparam int PW = cau_pkg::PW;
  localparam int SW = cau_pkg::SW;
  localparam int QB = cau_pkg::QB;
  localparam int NLOW = cau_pkg::NLOW;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Tolerance register
  logic [cau_pkg::TOL_BITS-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= cau_pkg::TOL_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      tol_q <= cfg_data_i;
    end
  end

  // Valid chain for the stages ahead of the divider, and the result strobe
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vdiv, done_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= start_i && !busy_o;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      done_q <= vdiv;
    end
  end

  // Stage 1: capture operands
  cau_pkg::op_e           op1_q;
  logic signed [W-1:0]    ar_q, ai_q, br_q, bi_q;
  always_ff @(posedge clk_i) begin
    op1_q <= cau_pkg::op_e'(op_i);
    ar_q  <= a_real_i;
    ai_q  <= a_imag_i;
    br_q  <= b_real_i;
    bi_q  <= b_imag_i;
  end

  // Stage 2: products and linear terms
  logic signed [W-1:0]    x0, x1;
  logic signed [PW-1:0]   m0_d, m1_d, m2_d, m3_d, m4_d, m5_d;
  logic signed [PW-1:0]   m0_q, m1_q, m2_q, m3_q, m4_q, m5_q;
  logic signed [W:0]      lre_d, lim_d, lre_q, lim_q;
  cau_pkg::op_e           op2_q;

  assign x0   = (op1_q == cau_pkg::OP_MOD) ? ar_q : br_q;
  assign x1   = (op1_q == cau_pkg::OP_MOD) ? ai_q : bi_q;
  assign m0_d = ar_q * x0;
  assign m1_d = ai_q * x1;
  assign m2_d = ai_q * br_q;
  assign m3_d = ar_q * bi_q;
  assign m4_d = br_q * br_q;
  assign m5_d = bi_q * bi_q;

  always_comb begin
    lre_d = '0;
    lim_d = '0;
    unique case (op1_q)
      cau_pkg::OP_ADD: begin
        lre_d = ar_q + br_q;
        lim_d = ai_q + bi_q;
      end
      cau_pkg::OP_SUB, cau_pkg::OP_EQ: begin
        lre_d = ar_q - br_q;
        lim_d = ai_q - bi_q;
      end
      cau_pkg::OP_CONJ: begin
        lre_d = ar_q;
        lim_d = -ai_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    op2_q <= op1_q;
    m0_q  <= m0_d;
    m1_q  <= m1_d;
    m2_q  <= m2_d;
    m3_q  <= m3_d;
    m4_q  <= m4_d;
    m5_q  <= m5_d;
    lre_q <= lre_d;
    lim_q <= lim_d;
  end

  // Stage 3: product sums, divisor, tolerance compare
  logic signed [PW:0]   sre_d, sim_d, sre_q, sim_q;
  logic [PW-1:0]        d3_d, d3_q;
  logic [W:0]           lare, laim;
  cau_pkg::side_t       sd3_d, sd3_q;

  assign d3_d = m4_q + m5_q;
  assign lare = lre_q[W] ? W'(-lre_q) + (W+1)'(0) : lre_q;
  assign laim = lim_q[W] ? W'(-lim_q) + (W+1)'(0) : lim_q;

  always_comb begin
    sre_d  = '0;
    sim_d  = '0;
    sd3_d  = '0;
    sd3_d.op = op2_q;
    unique case (op2_q)
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_CONJ: begin
        sd3_d.pre_re = SW'(lre_q);
        sd3_d.pre_im = SW'(lim_q);
      end
      cau_pkg::OP_MUL: begin
        sre_d = m0_q - m1_q;
        sim_d = m2_q + m3_q;
        sd3_d.pre_re = SW'(sre_d >>> F);
        sd3_d.pre_im = SW'(sim_d >>> F);
      end
      cau_pkg::OP_DIV: begin
        sre_d = m0_q + m1_q;
        sim_d = m2_q - m3_q;
      end
      cau_pkg::OP_MOD: begin
        sre_d = m0_q + m1_q;
        sd3_d.pre_re = SW'(sre_d >>> F);
      end
      cau_pkg::OP_EQ: begin
        sd3_d.eq = (lare <= (W+1)'(tol_q)) && (laim <= (W+1)'(tol_q));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    sre_q <= sre_d;
    sim_q <= sim_d;
    d3_q  <= d3_d;
    sd3_q <= sd3_d;
  end

  // Stage 4: numerator magnitudes and signs, zero divisor
  logic [PW-1:0]   nre4_q, nim4_q, d4_q;
  cau_pkg::side_t  sd4_d, sd4_q;

  always_comb begin
    sd4_d        = sd3_q;
    sd4_d.neg_re = sre_q[PW];
    sd4_d.neg_im = sim_q[PW];
    sd4_d.dz     = (d3_q == '0);
  end

  always_ff @(posedge clk_i) begin
    nre4_q <= sre_q[PW] ? PW'(-sre_q) : PW'(sre_q);
    nim4_q <= sim_q[PW] ? PW'(-sim_q) : PW'(sim_q);
    d4_q   <= d3_q;
    sd4_q  <= sd4_d;
  end

  // Stage 5: quotient overflow check (quotient would need more than QB bits)
  logic [PW-1:0]   nre5_q, nim5_q, d5_q;
  cau_pkg::side_t  sd5_d, sd5_q;

  always_comb begin
    sd5_d        = sd4_q;
    sd5_d.ovf_re = (nre4_q >> NLOW) >= d4_q;
    sd5_d.ovf_im = (nim4_q >> NLOW) >= d4_q;
  end

  always_ff @(posedge clk_i) begin
    nre5_q <= nre4_q;
    nim5_q <= nim4_q;
    d5_q   <= d4_q;
    sd5_q  <= sd5_d;
  end

  // Divider stages
  logic [QB-1:0]   qre, qim;
  cau_pkg::side_t  sdq;

  cau_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v5_q),
    .den_i   (d5_q),
    .nre_i   (nre5_q),
    .nim_i   (nim5_q),
    .side_i  (sd5_q),
    .valid_o (vdiv),
    .qre_o   (qre),
    .qim_o   (qim),
    .side_o  (sdq)
  );

  // Output stage: sign the quotient, pick the result, saturate
  logic [QB:0]           qqre, qqim;
  logic signed [SW-1:0]  xre, xim, vre, vim;
  cau_pkg::sat_t         sre_s, sim_s;
  cau_pkg::status_e      st_d;
  logic                  is_div;

  assign is_div = (sdq.op == cau_pkg::OP_DIV);
  assign qqre   = sdq.ovf_re ? ((QB+1)'(1) << QB) : {1'b0, qre};
  assign qqim   = sdq.ovf_im ? ((QB+1)'(1) << QB) : {1'b0, qim};
  assign xre    = SW'(qqre);
  assign xim    = SW'(qqim);

  always_comb begin
    vre = sdq.pre_re;
    vim = sdq.pre_im;
    if (is_div) begin
      if (sdq.dz) begin
        vre = '0;
        vim = '0;
      end else begin
        vre = sdq.neg_re ? -xre : xre;
        vim = sdq.neg_im ? -xim : xim;
      end
    end
  end

  assign sre_s = cau_pkg::saturate(vre);
  assign sim_s = cau_pkg::saturate(vim);

  always_comb begin
    priority if (is_div && sdq.dz) begin
      st_d = cau_pkg::ST_DIV0;
    end else if (sre_s.sat || sim_s.sat) begin
      st_d = cau_pkg::ST_SAT;
    end else begin
      st_d = cau_pkg::ST_OK;
    end
  end

  // Hold the result for its strobe cycle
  logic signed [W-1:0] ore_q, oim_q;
  logic                eq_q;
  logic [1:0]          st_q;
  always_ff @(posedge clk_i) begin
    ore_q <= sre_s.val;
    oim_q <= sim_s.val;
    eq_q  <= sdq.eq;
    st_q  <= st_d;
  end

  assign done_o     = done_q;
  assign out_real_o = ore_q;
  assign out_imag_o = oim_q;
  assign equal_o    = eq_q;
  assign status_o   = st_q;

endmodule

FILE: hdl/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker: port-level checks for the complex arithmetic unit
// Fixed latency in both directions and consistency of the result fields.
// ----------------------------------------------------------------------------
module cau_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start_i,
  input logic                          busy_o,
  input logic                          done_o,
  input logic [cau_pkg::WORD_BITS-1:0] out_real_o,
  input logic [cau_pkg::WORD_BITS-1:0] out_imag_o,
  input logic                          equal_o,
  input logic [1:0]                    status_o
);

  // Every accepted command gives a result after the pipeline latency
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##(cau_pkg::LATENCY) done_o)
    else $error("result missing after accepted command");

  // No result without a command transfer one latency earlier
  a_latency_bwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, cau_pkg::LATENCY))
    else $error("result without matching command");

  // A zero divisor yields a zero result
  a_div0_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == cau_pkg::ST_DIV0 |->
      out_real_o == '0 && out_imag_o == '0 && !equal_o)
    else $error("division by zero with nonzero result");

  // A compare hit carries zero components and ok status
  a_equal_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && equal_o |->
      status_o == cau_pkg::ST_OK && out_real_o == '0 && out_imag_o == '0)
    else $error("equal flag with unexpected result fields");

  // Status code three is never produced
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> status_o == cau_pkg::ST_OK || status_o == cau_pkg::ST_DIV0 ||
               status_o == cau_pkg::ST_SAT)
    else $error("undefined status code");

endmodule

bind complex_arithmetic_unit_top cau_checker u_cau_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start_i    (start_i),
  .busy_o     (busy_o),
  .done_o     (done_o),
  .out_real_o (out_real_o),
  .out_imag_o (out_imag_o),
  .equal_o    (equal_o),
  .status_o   (status_o)
);

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the complex arithmetic unit
// Drives directed and random commands with random gaps, rewrites the
// tolerance between phases, predicts every result in exact wide arithmetic
// and compares each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [cau_pkg::WORD_BITS-1:0] word_t;

  typedef struct {
    word_t            re;
    word_t            im;
    logic             eq;
    cau_pkg::status_e st;
  } cplx_result_t;

  // Predicts results of the unit and holds them until the result strobe
  class cplx_scoreboard;
    cplx_result_t pending[$];
    logic [cau_pkg::TOL_BITS-1:0] tol;
    int errors;

    function new();
      tol = cau_pkg::TOL_RESET;
      errors = 0;
    endfunction

    // Clamp a wide value to one word, flagging saturation
    function word_t clamp(input logic signed [199:0] x, inout cau_pkg::status_e st);
      if (x > 200'sd2147483647) begin
        st = cau_pkg::ST_SAT;
        return 32'sh7fffffff;
      end
      if (x < -200'sd2147483648) begin
        st = cau_pkg::ST_SAT;
        return 32'sh80000000;
      end
      return word_t'(x);
    endfunction

    // Truncating division toward zero of num * 2^FRAC_BITS by den
    function logic signed [199:0] quotient(input logic signed [199:0] num,
                                           input logic signed [199:0] den);
      logic signed [199:0] mag;
      logic signed [199:0] q;
      mag = (num < 0) ? -num : num;
      q = (mag <<< cau_pkg::FRAC_BITS) / den;
      return (num < 0) ? -q : q;
    endfunction

    function void note_command(input cau_pkg::op_e op, input word_t ar, input word_t ai,
                               input word_t br, input word_t bi);
      logic signed [199:0] xr, xi, yr, yi, re, im, den, dr, di;
      cplx_result_t r;
      xr = ar; xi = ai; yr = br; yi = bi;
      re = 0; im = 0;
      r.eq = 1'b0;
      r.st = cau_pkg::ST_OK;
      case (op)
        cau_pkg::OP_ADD: begin re = xr + yr; im = xi + yi; end
        cau_pkg::OP_SUB: begin re = xr - yr; im = xi - yi; end
        cau_pkg::OP_MUL: begin
          re = (xr * yr - xi * yi) >>> cau_pkg::FRAC_BITS;
          im = (xi * yr + xr * yi) >>> cau_pkg::FRAC_BITS;
        end
        cau_pkg::OP_DIV: begin
          den = yr * yr + yi * yi;
          if (den == 0) begin
            r.st = cau_pkg::ST_DIV0;
          end else begin
            re = quotient(xr * yr + xi * yi, den);
            im = quotient(xi * yr - xr * yi, den);
          end
        end
        cau_pkg::OP_CONJ: begin re = xr; im = -xi; end
        cau_pkg::OP_MOD: re = (xr * xr + xi * xi) >>> cau_pkg::FRAC_BITS;
        cau_pkg::OP_EQ: begin
          dr = xr - yr; di = xi - yi;
          if (dr < 0) dr = -dr;
          if (di < 0) di = -di;
          r.eq = (dr <= $signed({169'd0, tol})) && (di <= $signed({169'd0, tol}));
        end
        default: ;
      endcase
      r.re = clamp(re, r.st);
      r.im = clamp(im, r.st);
      pending.push_back(r);
    endfunction

    function void check_result(input word_t re, input word_t im, input logic eq,
                               input logic [1:0] st);
      cplx_result_t e;
      if (pending.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (re !== e.re) begin
        $error("out_real: expected %0d, actual %0d", e.re, re); errors++;
      end
      if (im !== e.im) begin
        $error("out_imag: expected %0d, actual %0d", e.im, im); errors++;
      end
      if (eq !== e.eq) begin
        $error("equal: expected %0b, actual %0b", e.eq, eq); errors++;
      end
      if (st !== e.st) begin
        $error("status: expected %0d, actual %0d", e.st, st); errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic [2:0] op_i = '0;
  word_t a_real_i = '0, a_imag_i = '0, b_real_i = '0, b_imag_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [cau_pkg::TOL_BITS-1:0] cfg_data_i = '0;
  logic done_o;
  word_t out_real_o, out_imag_o;
  logic equal_o;
  logic [1:0] status_o;

  cplx_scoreboard sb = new();
  int gap_pct;

  complex_arithmetic_unit_top dut (.*);

  always #5 clk_i = ~clk_i;

  // Check every strobed result
  always @(posedge clk_i) begin
    if (done_o) sb.check_result(out_real_o, out_imag_o, equal_o, status_o);
  end

  // Note commands at the accepting edge
  always @(posedge clk_i) begin
    if (rst_ni && start_i && !busy_o)
      sb.note_command(cau_pkg::op_e'(op_i), a_real_i, a_imag_i, b_real_i, b_imag_i);
  end

  // Issue one command, with a random gap ahead of it
  task automatic send_command(input cau_pkg::op_e op, input word_t ar, input word_t ai,
                              input word_t br, input word_t bi);
    while ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    op_i <= op;
    a_real_i <= ar; a_imag_i <= ai; b_real_i <= br; b_imag_i <= bi;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  // Wait until all results are in, plus the pipeline depth
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (cau_pkg::LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_tolerance(input logic [cau_pkg::TOL_BITS-1:0] tol);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= tol;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.tol = tol;
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random operand: half modest values, else full range, extremes or zero
  function automatic word_t rand_word();
    case ($urandom_range(9))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2, 3: return word_t'($urandom);
      4: return 0;
      default: return word_t'($signed($urandom_range(32'h0fffff)) - 32'sh80000);
    endcase
  endfunction

  task automatic random_commands(input int count);
    word_t ar, ai, br, bi;
    for (int i = 0; i < count; i++) begin
      ar = rand_word(); ai = rand_word(); br = rand_word(); bi = rand_word();
      // Near-equal pairs so the compare goes both ways
      if ($urandom_range(3) == 0) begin
        br = ar + word_t'($signed($urandom_range(2000)) - 1000);
        bi = ai + word_t'($signed($urandom_range(2000)) - 1000);
      end
      send_command(cau_pkg::op_e'($urandom_range(7)), ar, ai, br, bi);
    end
  endtask

  initial begin
    gap_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: every op, extremes, zero divisor, saturation cases
    send_command(cau_pkg::OP_ADD, 32'sh7fffffff, 32'sh80000000, 32'sh1, -32'sh1);
    send_command(cau_pkg::OP_ADD, 32'sh10000, 32'sh20000, 32'sh30000, -32'sh40000);
    send_command(cau_pkg::OP_SUB, 32'sh80000000, 32'sh7fffffff, 32'sh1, -32'sh1);
    send_command(cau_pkg::OP_MUL, 32'sh20000, 32'sh30000, -32'sh10000, 32'sh8000);
    send_command(cau_pkg::OP_MUL, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                 32'sh7fffffff);
    send_command(cau_pkg::OP_MUL, -32'sh1, 32'sh0, 32'sh1, 32'sh0);
    send_command(cau_pkg::OP_DIV, 32'sh10000, 32'sh10000, 32'sh0, 32'sh0);
    send_command(cau_pkg::OP_DIV, 32'sh30000, -32'sh10000, 32'sh20000, 32'sh10000);
    send_command(cau_pkg::OP_DIV, 32'sh7fffffff, 32'sh80000000, 32'sh1, 32'sh0);
    send_command(cau_pkg::OP_DIV, -32'sh1, 32'sh1, 32'sh7fffffff, 32'sh80000000);
    send_command(cau_pkg::OP_CONJ, 32'sh12345, 32'sh80000000, 32'sh0, 32'sh0);
    send_command(cau_pkg::OP_CONJ, 32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh0);
    send_command(cau_pkg::OP_MOD, 32'sh80000000, 32'sh80000000, 32'sh0, 32'sh0);
    send_command(cau_pkg::OP_MOD, -32'sh18000, 32'sh8000, 32'sh0, 32'sh0);
    send_command(cau_pkg::OP_EQ, 32'sh10000, 32'sh10000, 32'sh1028f, 32'shfd71);
    send_command(cau_pkg::OP_EQ, 32'sh10000, 32'sh10000, 32'sh10290, 32'sh10000);
    send_command(cau_pkg::OP_EQ, 32'sh7fffffff, 32'sh0, 32'sh80000000, 32'sh0);
    send_command(cau_pkg::OP_NONE, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                 32'sh7fffffff);
    drain();

    // Extreme tolerances with compare-heavy traffic
    write_tolerance('0);
    send_command(cau_pkg::OP_EQ, 32'sh5, 32'sh5, 32'sh5, 32'sh5);
    send_command(cau_pkg::OP_EQ, 32'sh5, 32'sh5, 32'sh6, 32'sh5);
    drain();
    write_tolerance('1);
    send_command(cau_pkg::OP_EQ, 32'sh7fffffff, 32'sh0, 32'sh0, 32'sh0);
    send_command(cau_pkg::OP_EQ, 32'sh7fffffff, 32'sh0, 32'sh80000000, 32'sh0);
    drain();

    // Random phases: sender gaps, then heavy gaps, then back to back
    write_tolerance(cau_pkg::TOL_BITS'($urandom_range(1000)));
    gap_pct = 22;
    random_commands(170);
    drain();
    write_tolerance(cau_pkg::TOL_BITS'($urandom));
    gap_pct = 84;
    random_commands(160);
    drain();
    write_tolerance(cau_pkg::TOL_RESET);
    gap_pct = 0;
    random_commands(170);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Run limit well above the slowest correct run
  initial begin
    #2ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule

FILE: complex_arithmetic_unit_top.f
hdl/cau_pkg.sv
hdl/cau_div_pipe.sv
hdl/complex_arithmetic_unit_top.sv
hdl/cau_checker.sv
tb/tb_top.sv
